// File: design/kts_pkg.sv
// Package for the key/tag sorter: shared widths, default depth and cell types.
// Used by kts_cell and key_tag_sorter_unit; depends on nothing.
`default_nettype none

package kts_pkg;

    // Default number of cells in the chain.
    localparam int KTS_MAX_ITEMS = 64;

    localparam int KTS_KEY_W = 32;
    localparam int KTS_TAG_W = 16;

    // Contents of one cell: an occupied mark, a signed key and its tag.
    typedef struct packed {
        logic                        valid;
        logic signed [KTS_KEY_W-1:0] key;
        logic        [KTS_TAG_W-1:0] tag;
    } cell_data_t;

    // Per-cycle command broadcast to every cell.
    typedef struct packed {
        logic insert;   // a new pair enters the sorted row
        logic shift;    // the row moves one place toward cell 0
    } cell_cmd_t;

endpackage

`default_nettype wire

// File: design/kts_cell.sv
// One cell of the sorting chain: holds one pair and trades it with its neighbors.
// Depends on kts_pkg for the cell data and command types.
`default_nettype none

module kts_cell
    import kts_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire cell_cmd_t  cmd,
    input  wire cell_data_t new_item,
    input  wire cell_data_t left_data,
    input  wire logic       left_gt,
    input  wire cell_data_t right_data,
    output cell_data_t      data,
    output logic            gt
);

    logic                        valid_reg;
    logic signed [KTS_KEY_W-1:0] key_reg;
    logic        [KTS_TAG_W-1:0] tag_reg;
    cell_data_t                  data_next;

    assign data = '{valid: valid_reg, key: key_reg, tag: tag_reg};

    // An empty cell counts as holding an infinitely large key. Equal keys do
    // not displace, so earlier arrivals stay in front.
    always_comb
    begin
        gt = !valid_reg || ($signed(new_item.key) < key_reg);
    end

    // Take the new pair at the insertion point, the left neighbor's pair
    // behind it, or the right neighbor's pair while draining.
    always_comb
    begin
        data_next = data;
        if (cmd.insert && gt)
        begin
            data_next = left_gt ? left_data : new_item;
        end
        else if (cmd.shift)
        begin
            data_next = right_data;
        end
    end

    // The occupied mark is control state and is reset.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= data_next.valid;
        end
    end

    // Key and tag are payload and need no reset.
    always_ff @(posedge clk)
    begin
        key_reg <= data_next.key;
        tag_reg <= data_next.tag;
    end

endmodule

`default_nettype wire

// File: design/key_tag_sorter_unit.sv
// Top level of the key/tag sorter: a chain of MAX_ITEMS kts_cell instances
// and the load/drain control. Depends on kts_pkg and kts_cell.
`default_nettype none

// The block takes one (key, tag) beat per cycle while a set loads: every cell
// compares the incoming key at once and the row shifts open at the insertion
// point, so the chain is always sorted and loading never stalls. The beat
// marked last closes the set. From the next cycle on, the sorted pairs leave
// from cell 0 at up to one beat per cycle, smallest key first, equal keys in
// arrival order, the final beat carrying end_of_set. A set that stored n pairs
// gives n result beats; the input is stalled during those n beats and the
// next set can start the cycle after the final one is taken. Beats that
// arrive when all MAX_ITEMS cells are full are dropped, and every result of
// that set then carries overflow.
module key_tag_sorter_unit
    import kts_pkg::*;
#(
    parameter int MAX_ITEMS = KTS_MAX_ITEMS
)
(
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        in_valid,
    output logic                             in_stall,
    input  wire logic signed [KTS_KEY_W-1:0] key,
    input  wire logic        [KTS_TAG_W-1:0] tag,
    input  wire logic                        last,
    output logic                             out_valid,
    input  wire logic                        out_stall,
    output logic             [KTS_TAG_W-1:0] sorted_tag,
    output logic signed      [KTS_KEY_W-1:0] sorted_key,
    output logic                             end_of_set,
    output logic                             overflow
);

    logic       drain_reg;
    logic       drain_next;
    logic       dropped_reg;
    logic       dropped_next;
    logic       in_beat;
    logic       out_beat;
    logic       full;
    cell_cmd_t  cmd;
    cell_data_t new_item;

    cell_data_t cell_data [MAX_ITEMS];
    logic       cell_gt   [MAX_ITEMS];

    // Handshake and chain commands.
    assign full      = cell_data[MAX_ITEMS-1].valid;
    assign in_stall  = drain_reg;
    assign in_beat   = in_valid && !drain_reg;
    assign out_valid = drain_reg && cell_data[0].valid;
    assign out_beat  = out_valid && !out_stall;

    assign cmd.insert = in_beat && !full;
    assign cmd.shift  = out_beat;

    assign new_item.valid = 1'b1;
    assign new_item.key   = key;
    assign new_item.tag   = tag;

    // Result beat comes straight from the head of the chain.
    assign sorted_tag = cell_data[0].tag;
    assign sorted_key = cell_data[0].key;
    assign end_of_set = !cell_data[1].valid;
    assign overflow   = dropped_reg;

    // The row of cells, each wired to its two neighbors.
    for (genvar i = 0; i < MAX_ITEMS; i++)
    begin : g_cell
        cell_data_t left_d;
        cell_data_t right_d;
        logic       left_g;

        if (i == 0)
        begin : g_first
            assign left_d = '0;
            assign left_g = 1'b0;
        end
        else
        begin : g_inner_left
            assign left_d = cell_data[i-1];
            assign left_g = cell_gt[i-1];
        end

        if (i == MAX_ITEMS - 1)
        begin : g_final
            assign right_d = '0;
        end
        else
        begin : g_inner_right
            assign right_d = cell_data[i+1];
        end

        kts_cell u_cell (
            .clk        (clk),
            .rst_n      (rst_n),
            .cmd        (cmd),
            .new_item   (new_item),
            .left_data  (left_d),
            .left_gt    (left_g),
            .right_data (right_d),
            .data       (cell_data[i]),
            .gt         (cell_gt[i])
        );
    end

    // Load/drain control and the dropped-beat mark.
    always_comb
    begin
        drain_next   = drain_reg;
        dropped_next = dropped_reg;
        if (in_beat)
        begin
            if (full)
            begin
                dropped_next = 1'b1;
            end
            if (last)
            begin
                drain_next = 1'b1;
            end
        end
        if (out_beat && end_of_set)
        begin
            drain_next   = 1'b0;
            dropped_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            drain_reg   <= 1'b0;
            dropped_reg <= 1'b0;
        end
        else
        begin
            drain_reg   <= drain_next;
            dropped_reg <= dropped_next;
        end
    end

endmodule

`default_nettype wire

// File: tb/sv/tb_key_tag_sorter_unit.sv
// Self-checking testbench for key_tag_sorter_unit: drives sets of key/tag beats,
// predicts the stable ascending order and checks every result beat. Needs kts_pkg.
`default_nettype none

module tb_key_tag_sorter_unit;
    import kts_pkg::*;

    localparam int DEPTH = KTS_MAX_ITEMS;

    logic                        clk;
    logic                        rst_n;
    logic                        in_valid;
    logic                        in_stall;
    logic signed [KTS_KEY_W-1:0] key;
    logic        [KTS_TAG_W-1:0] tag;
    logic                        last;
    logic                        out_valid;
    logic                        out_stall;
    logic        [KTS_TAG_W-1:0] sorted_tag;
    logic signed [KTS_KEY_W-1:0] sorted_key;
    logic                        end_of_set;
    logic                        overflow;

    // One predicted result beat.
    typedef struct {
        logic        [KTS_TAG_W-1:0] tag;
        logic signed [KTS_KEY_W-1:0] key;
        logic                        eos;
        logic                        ovf;
    } sorted_beat_t;

    // Keeps its own copy of the held pairs and sorts them when a set closes.
    class sort_scoreboard;
        logic signed [KTS_KEY_W-1:0] held_key [DEPTH];
        logic        [KTS_TAG_W-1:0] held_tag [DEPTH];
        int           held_count = 0;
        bit           dropped = 0;
        sorted_beat_t sorted_q [$];
        int           errors = 0;
        int           results_checked = 0;
        int           overflow_sets = 0;

        // Store or drop one accepted input beat; on last, queue the sorted set.
        function void note_input(logic signed [KTS_KEY_W-1:0] k,
                                 logic [KTS_TAG_W-1:0] t, logic l);
            int order [DEPTH];
            int i;
            int j;
            sorted_beat_t b;
            if (held_count < DEPTH)
            begin
                held_key[held_count] = k;
                held_tag[held_count] = t;
                held_count++;
            end
            else
                dropped = 1;
            if (!l)
                return;
            // Stable insertion sort: a later pair moves only past strictly larger keys.
            for (i = 0; i < held_count; i++)
            begin
                j = i;
                while (j > 0 && held_key[i] < held_key[order[j-1]])
                begin
                    order[j] = order[j-1];
                    j--;
                end
                order[j] = i;
            end
            for (i = 0; i < held_count; i++)
            begin
                b.tag = held_tag[order[i]];
                b.key = held_key[order[i]];
                b.eos = (i == held_count - 1);
                b.ovf = dropped;
                sorted_q.push_back(b);
            end
            if (dropped)
                overflow_sets++;
            held_count = 0;
            dropped = 0;
        endfunction

        function void compare_field(string name, logic [31:0] want, logic [31:0] got);
            if (want !== got)
            begin
                errors++;
                $display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
            end
        endfunction

        // Compare one accepted result beat with the oldest prediction.
        function void check_result(logic [KTS_TAG_W-1:0] t, logic signed [KTS_KEY_W-1:0] k,
                                   logic eos, logic ovf);
            sorted_beat_t b;
            results_checked++;
            if (sorted_q.size() == 0)
            begin
                errors++;
                $display("%0t: unexpected result beat, expected none, actual tag %h key %h",
                         $time, t, k);
                return;
            end
            b = sorted_q.pop_front();
            compare_field("sorted_tag", b.tag, t);
            compare_field("sorted_key", b.key, k);
            compare_field("end_of_set", b.eos, eos);
            compare_field("overflow", b.ovf, ovf);
        endfunction
    endclass

    sort_scoreboard sb = new();
    bit quiet = 0;
    int beats_sent = 0;
    int sets_sent = 0;

    key_tag_sorter_unit DUT (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .key        (key),
        .tag        (tag),
        .last       (last),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .sorted_tag (sorted_tag),
        .sorted_key (sorted_key),
        .end_of_set (end_of_set),
        .overflow   (overflow)
    );

    // Clock generation.
    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Run limit, far beyond the slowest correct run.
    initial
    begin
        #2000000;
        $display("%0t: timeout, %0d result beats still outstanding", $time, sb.sorted_q.size());
        $display("** key_tag_sorter_unit: FAILED **");
        $finish;
    end

    // Offer one beat after an optional random gap and wait until it is taken.
    task automatic send_beat(logic signed [KTS_KEY_W-1:0] k, logic [KTS_TAG_W-1:0] t,
                             logic l);
        while (!quiet && $urandom_range(0, 99) < 36)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        key      <= k;
        tag      <= t;
        last     <= l;
        do
            @(posedge clk);
        while (in_stall);
        sb.note_input(k, t, l);
        beats_sent++;
        if (l)
            sets_sent++;
    endtask

    // Mix of extreme keys, a narrow band that makes ties, and full-range keys.
    function automatic logic signed [KTS_KEY_W-1:0] pick_key();
        int mode;
        mode = $urandom_range(0, 9);
        case (mode)
            0: case ($urandom_range(0, 4))
                   0: return 32'sh8000_0000;
                   1: return 32'sh7FFF_FFFF;
                   2: return -1;
                   3: return 0;
                   default: return 1;
               endcase
            1, 2, 3: return $signed($urandom_range(0, 7)) - 4;
            default: return $urandom;
        endcase
    endfunction

    task automatic send_set(int n);
        int i;
        for (i = 0; i < n; i++)
            send_beat(pick_key(), 16'($urandom_range(0, 65535)), i == n - 1);
    endtask

    // Result side: checks every accepted beat and stalls at random, with one long hold.
    initial
    begin
        int  hold_left;
        bit  hold_done;
        hold_left = 0;
        hold_done = 0;
        out_stall <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (rst_n && out_valid && !out_stall)
                sb.check_result(sorted_tag, sorted_key, end_of_set, overflow);
            if (!hold_done && sb.results_checked >= 60)
            begin
                hold_left = 150;
                hold_done = 1;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                out_stall <= 1'b1;
            end
            else
                out_stall <= !quiet && ($urandom_range(0, 99) < 36);
        end
    end

    // Stimulus: reset, directed sets, then random sets until about 370 beats.
    initial
    begin
        logic signed [KTS_KEY_W-1:0] mixed_keys [9];
        int i;
        int set_idx;
        mixed_keys = '{0, -1, 32'sh7FFF_FFFF, 32'sh8000_0000, 1, 5, 5, -1, 5};
        rst_n    <= 1'b0;
        in_valid <= 1'b0;
        key      <= '0;
        tag      <= '0;
        last     <= 1'b0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Single-beat sets at both extremes of key and tag.
        send_beat(32'sh7FFF_FFFF, 16'hFFFF, 1'b1);
        send_beat(32'sh8000_0000, 16'h0000, 1'b1);
        // Extremes, signs and repeated keys in one set.
        for (i = 0; i < 9; i++)
            send_beat(mixed_keys[i], 16'(16'h0100 + i), i == 8);
        // All keys equal: the tags must come back in arrival order.
        send_beat(7, 16'h0003, 1'b0);
        send_beat(7, 16'h0002, 1'b0);
        send_beat(7, 16'h0001, 1'b1);
        // Descending pair.
        send_beat(100, 16'hAAAA, 1'b0);
        send_beat(-100, 16'h5555, 1'b1);

        // Let the block drain completely before the random part.
        in_valid <= 1'b0;
        while (sb.sorted_q.size() != 0)
            @(posedge clk);

        // Random sets; a few fill the store exactly, drop the last beat, or overrun it.
        set_idx = 0;
        while (beats_sent < 370)
        begin
            quiet = (set_idx >= 14 && set_idx < 20);
            case (set_idx)
                5:       send_set(DEPTH);
                10:      send_set(DEPTH + 1);
                24:      send_set(DEPTH + 6);
                default: send_set($urandom_range(1, 12));
            endcase
            set_idx++;
        end
        quiet = 0;
        in_valid <= 1'b0;

        while (sb.sorted_q.size() != 0)
            @(posedge clk);
        repeat (20) @(posedge clk);

        $display("Sent %0d input beats in %0d sets (%0d over capacity); checked %0d results.",
                 beats_sent, sets_sent, sb.overflow_sets, sb.results_checked);
        if (sb.errors == 0)
            $display("** key_tag_sorter_unit: PASSED **");
        else
            $display("** key_tag_sorter_unit: FAILED **");
        $finish;
    end

endmodule

`default_nettype wire
